@@ sv/bbaf_pkg.sv @@
// Package for the beacon advertising filter: types, register indexes and constants.
`default_nettype none

package bbaf_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegVendorId      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMagicWord     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFormatVersion = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEventCode     = 3'd3;

  // Register reset values
  localparam logic [15:0] VendorIdRst      = 16'hFFFF;
  localparam logic [15:0] MagicWordRst     = 16'h4346;
  localparam logic [7:0]  FormatVersionRst = 8'h01;
  localparam logic [7:0]  EventCodeRst     = 8'h01;

  // AD structure constants
  localparam logic [7:0] MfrType   = 8'hFF;
  localparam logic [7:0] MinMfrLen = 8'd9;

  // Offsets within a manufacturer-data structure
  localparam logic [4:0] OffType    = 5'd1;
  localparam logic [4:0] OffVendHi  = 5'd2;
  localparam logic [4:0] OffVendLo  = 5'd3;
  localparam logic [4:0] OffMagicHi = 5'd4;
  localparam logic [4:0] OffMagicLo = 5'd5;
  localparam logic [4:0] OffVersion = 5'd6;
  localparam logic [4:0] OffEvent   = 5'd7;
  localparam logic [4:0] OffSeq     = 5'd8;
  localparam logic [4:0] OffBattery = 5'd9;

  // Item kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindPoll = 1'b1;

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] magic_word;
    logic [7:0]  format_version;
    logic [7:0]  event_code;
  } cfg_t;

  typedef struct packed {
    logic       new_shake;
    logic [7:0] shake_seq;
    logic [7:0] battery_level;
    logic       event_taken;
  } res_t;

  typedef struct packed {
    logic event_pending;
    logic have_last;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/bbaf_walker.sv @@
// AD structure walker, beacon matcher and pending-event tracker.
`default_nettype none

module bbaf_walker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bbaf_pkg::cfg_t cfg_i,
  input  wire logic           accept_i,
  input  wire logic           kind_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic [7:0]     report_length_i,
  output bbaf_pkg::res_t      result_o,
  output bbaf_pkg::stat_t     status_o
);
  import bbaf_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] nhp_q, nhp_d;
  logic       stopped_q, stopped_d;
  logic       cand_q, cand_d;
  logic       match_q, match_d;
  logic [3:0] offs_q, offs_d;
  logic [7:0] cap_q, cap_d;
  logic [7:0] last_q, last_d;
  logic       have_q, have_d;
  logic       pend_q, pend_d;

  logic [8:0] pos_inc;
  logic [8:0] struct_end;
  logic [4:0] off;
  logic       report_end;
  res_t       res;

  assign pos_inc    = {1'b0, pos_q} + 9'd1;
  assign struct_end = pos_inc + {1'b0, data_byte_i};
  assign off        = {1'b0, offs_q} + 5'd1;
  assign report_end = pos_inc >= {1'b0, report_length_i};

  // Compute next state and the result of the current item
  always_comb begin
    pos_d     = pos_q;
    nhp_d     = nhp_q;
    stopped_d = stopped_q;
    cand_d    = cand_q;
    match_d   = match_q;
    offs_d    = offs_q;
    cap_d     = cap_q;
    last_d    = last_q;
    have_d    = have_q;
    pend_d    = pend_q;
    res       = '0;

    if (kind_i == KindPoll) begin
      // take the pending flag
      if (pend_q) begin
        pend_d          = 1'b0;
        res.event_taken = 1'b1;
      end
    end else begin
      if (!stopped_q) begin
        if (pos_q == nhp_q) begin
          // length byte of a new structure
          cand_d  = 1'b0;
          match_d = 1'b0;
          offs_d  = '0;
          if (report_end || data_byte_i == 8'd0 ||
              struct_end > {1'b0, report_length_i}) begin
            stopped_d = 1'b1;
          end else begin
            nhp_d  = struct_end[7:0];
            cand_d = data_byte_i >= MinMfrLen;
          end
        end else if (cand_q) begin
          offs_d = off[3:0];
          unique case (off)
            OffType:    match_d = data_byte_i == MfrType;
            OffVendHi:  match_d = match_q && (data_byte_i == cfg_i.vendor_id[15:8]);
            OffVendLo:  match_d = match_q && (data_byte_i == cfg_i.vendor_id[7:0]);
            OffMagicHi: match_d = match_q && (data_byte_i == cfg_i.magic_word[15:8]);
            OffMagicLo: match_d = match_q && (data_byte_i == cfg_i.magic_word[7:0]);
            OffVersion: match_d = match_q && (data_byte_i == cfg_i.format_version);
            OffEvent:   match_d = match_q && (data_byte_i == cfg_i.event_code);
            OffSeq:     cap_d   = data_byte_i;
            OffBattery: begin
              // accept a non-duplicate matching beacon
              if (match_q && !(have_q && cap_q == last_q)) begin
                have_d            = 1'b1;
                last_d            = cap_q;
                pend_d            = 1'b1;
                res.new_shake     = 1'b1;
                res.shake_seq     = cap_q;
                res.battery_level = data_byte_i;
              end
              cand_d  = 1'b0;
              match_d = 1'b0;
            end
            default:    cand_d  = 1'b0;
          endcase
        end
      end

      // advance or restart at the report end
      if (report_end) begin
        pos_d     = '0;
        nhp_d     = '0;
        stopped_d = 1'b0;
        cand_d    = 1'b0;
        match_d   = 1'b0;
        offs_d    = '0;
      end else begin
        pos_d = pos_inc[7:0];
      end
    end
  end

  // Update state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      nhp_q     <= '0;
      stopped_q <= 1'b0;
      cand_q    <= 1'b0;
      match_q   <= 1'b0;
      offs_q    <= '0;
      cap_q     <= '0;
      last_q    <= '0;
      have_q    <= 1'b0;
      pend_q    <= 1'b0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      nhp_q     <= nhp_d;
      stopped_q <= stopped_d;
      cand_q    <= cand_d;
      match_q   <= match_d;
      offs_q    <= offs_d;
      cap_q     <= cap_d;
      last_q    <= last_d;
      have_q    <= have_d;
      pend_q    <= pend_d;
    end
  end

  assign result_o               = res;
  assign status_o.event_pending = pend_q;
  assign status_o.have_last     = have_q;

endmodule

`default_nettype wire

@@ sv/ble_beacon_adv_filter.sv @@
// Top level of the beacon advertising filter: config registers, walker and result register.
`default_nettype none

// Takes one item per cycle: either a byte of an advertising report (with the report
// length on every byte) or a poll. Every item gives exactly one result, registered and
// shown in the cycle after acceptance. The parser state advances on each accepted byte,
// and the result register takes a new result in the same cycle the previous one is
// taken, so the sustained rate is one item per clock whenever the output side is ready.
// A beacon result carries new_shake with its sequence and battery bytes; a poll result
// carries event_taken. Configuration registers (index 0 vendor id, 1 magic word, 2 format
// version, 3 event code) are written by the user only while the block idles (not enforced).
module ble_beacon_adv_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bbaf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bbaf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic [7:0]                    report_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               new_shake_o,
  output logic [7:0]                         shake_seq_o,
  output logic [7:0]                         battery_level_o,
  output logic                               event_taken_o
);
  import bbaf_pkg::*;

  cfg_t  cfg_q;
  res_t  res;
  res_t  res_q;
  stat_t status;
  logic  out_valid_q;
  logic  in_acc;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vendor_id      <= VendorIdRst;
      cfg_q.magic_word     <= MagicWordRst;
      cfg_q.format_version <= FormatVersionRst;
      cfg_q.event_code     <= EventCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVendorId:      cfg_q.vendor_id      <= cfg_data_i;
        RegMagicWord:     cfg_q.magic_word     <= cfg_data_i;
        RegFormatVersion: cfg_q.format_version <= cfg_data_i[7:0];
        RegEventCode:     cfg_q.event_code     <= cfg_data_i[7:0];
        default:          ;
      endcase
    end
  end

  // Accept while the result slot is empty or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  bbaf_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .accept_i        (in_acc),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .report_length_i (report_length_i),
    .result_o        (res),
    .status_o        (status)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_shake_o     = res_q.new_shake;
  assign shake_seq_o     = res_q.shake_seq;
  assign battery_level_o = res_q.battery_level;
  assign event_taken_o   = res_q.event_taken;

`ifndef ASSERT_OFF
  // A result is either a beacon or a taken poll, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(new_shake_o && event_taken_o))
    else $error("beacon and poll flags both set");

  // Without a beacon the sequence and battery fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !new_shake_o) |-> (shake_seq_o == 8'd0 && battery_level_o == 8'd0))
    else $error("payload set on a result without a beacon");

  // An accepted beacon leaves an event pending and a last sequence recorded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.new_shake) |=> (status.event_pending && status.have_last))
    else $error("beacon accepted without pending event");

  // A poll with an event pending returns it and clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KindPoll && status.event_pending)
      |=> (out_valid_o && event_taken_o && !status.event_pending))
    else $error("pending event not taken by poll");
`endif

endmodule

`default_nettype wire
